/* src/gqi_pkg.sv */
// ----------------------------------------------------------------------------
// gqi_pkg
// Shared types and constants of the gaze quadrant interpolator: result status
// codes, register indexes, bus widths and the control word that rides along
// the pipeline.
// ----------------------------------------------------------------------------
package gqi_pkg;

    localparam int PDATA_W      = 64;
    localparam int PADDR_W      = 5;
    localparam int REG_ADDR_LSB = 3;
    localparam int REG_IDX_W    = PADDR_W - REG_ADDR_LSB;

    localparam logic [REG_IDX_W-1:0] REG_CENTER       = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOP_LEFT     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_EYES   = 2'd1,
        STATUS_ZERO_SPAN = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic    x_right;
        logic    y_right;
        logic    x_neg;
        logic    y_neg;
    } ctrl_t;

endpackage

/* src/gqi_in_if.sv */
// ----------------------------------------------------------------------------
// gqi_in_if
// Eye sample channel: found flag and both pupil positions per beat.
// ----------------------------------------------------------------------------
interface gqi_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  eyes_found;
    logic [COORD_BITS-1:0] left_eye_x;
    logic [COORD_BITS-1:0] left_eye_y;
    logic [COORD_BITS-1:0] right_eye_x;
    logic [COORD_BITS-1:0] right_eye_y;

    modport source (
        output valid, eyes_found, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
        input  ready
    );

    modport sink (
        input  valid, eyes_found, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
        output ready
    );
endinterface

/* src/gqi_out_if.sv */
// ----------------------------------------------------------------------------
// gqi_out_if
// Gaze result channel: status, screen point and clip flag per beat.
// ----------------------------------------------------------------------------
interface gqi_out_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    gqi_pkg::status_t      status;
    logic [COORD_BITS-1:0] gaze_x;
    logic [COORD_BITS-1:0] gaze_y;
    logic                  clipped;

    modport source (
        output valid, status, gaze_x, gaze_y, clipped,
        input  ready
    );

    modport sink (
        input  valid, status, gaze_x, gaze_y, clipped,
        output ready
    );
endinterface

/* src/gqi_cfg_regs.sv */
// ----------------------------------------------------------------------------
// gqi_cfg_regs
// APB register file holding the three calibration points, each four packed
// coordinates: left x, left y, right x, right y, lowest first.
// ----------------------------------------------------------------------------
module gqi_cfg_regs #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gqi_pkg::PADDR_W-1:0]  paddr,
    input  logic [gqi_pkg::PDATA_W-1:0]  pwdata,
    output logic [gqi_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [4*COORD_BITS-1:0]      center,
    output logic [4*COORD_BITS-1:0]      upper_left,
    output logic [4*COORD_BITS-1:0]      lower_right
);

    localparam int REG_W = 4 * COORD_BITS;

    logic [REG_W-1:0]                center_reg;
    logic [REG_W-1:0]                upper_left_reg;
    logic [REG_W-1:0]                lower_right_reg;
    logic [gqi_pkg::REG_IDX_W-1:0]   reg_idx;

    assign reg_idx = paddr[gqi_pkg::PADDR_W-1:gqi_pkg::REG_ADDR_LSB];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg      <= '0;
            upper_left_reg  <= '0;
            lower_right_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                gqi_pkg::REG_CENTER:       center_reg      <= pwdata[REG_W-1:0];
                gqi_pkg::REG_TOP_LEFT:     upper_left_reg  <= pwdata[REG_W-1:0];
                gqi_pkg::REG_BOTTOM_RIGHT: lower_right_reg <= pwdata[REG_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gqi_pkg::REG_CENTER:       prdata = gqi_pkg::PDATA_W'(center_reg);
            gqi_pkg::REG_TOP_LEFT:     prdata = gqi_pkg::PDATA_W'(upper_left_reg);
            gqi_pkg::REG_BOTTOM_RIGHT: prdata = gqi_pkg::PDATA_W'(lower_right_reg);
            default:                   prdata = '0;
        endcase
    end

    assign center      = center_reg;
    assign upper_left  = upper_left_reg;
    assign lower_right = lower_right_reg;

endmodule

/* src/gqi_front.sv */
// ----------------------------------------------------------------------------
// gqi_front
// Two pipeline stages: quadrant pick with summed distance and span per axis,
// then status decision and magnitudes for the dividers.
// ----------------------------------------------------------------------------
module gqi_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic                         eyes_found,
    input  logic [COORD_BITS-1:0]        left_eye_x,
    input  logic [COORD_BITS-1:0]        left_eye_y,
    input  logic [COORD_BITS-1:0]        right_eye_x,
    input  logic [COORD_BITS-1:0]        right_eye_y,
    input  logic [4*COORD_BITS-1:0]      center,
    input  logic [4*COORD_BITS-1:0]      upper_left,
    input  logic [4*COORD_BITS-1:0]      lower_right,
    output logic                         out_valid,
    output gqi_pkg::ctrl_t               ctrl,
    output logic [COORD_BITS:0]          dx_abs,
    output logic [COORD_BITS:0]          dy_abs,
    output logic [COORD_BITS+1:0]        den_x,
    output logic [COORD_BITS+1:0]        den_y,
    output logic [COORD_BITS-1:0]        min_x,
    output logic [COORD_BITS-1:0]        min_y,
    output logic signed [COORD_BITS:0]   len_x,
    output logic signed [COORD_BITS:0]   len_y
);

    localparam int C  = COORD_BITS;
    localparam int SW = COORD_BITS + 2;

    function automatic logic signed [SW-1:0] ext(input logic [C-1:0] a);
        return $signed({2'b00, a});
    endfunction

    function automatic logic [C:0] mag(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = v[SW-1] ? -v : v;
        return m[C:0];
    endfunction

    logic [C-1:0] c_lx, c_ly, c_rx, c_ry;
    logic [C-1:0] t_lx, t_ly, t_rx, t_ry;
    logic [C-1:0] b_lx, b_ly, b_rx, b_ry;

    assign c_lx = center[0 +: C];
    assign c_ly = center[C +: C];
    assign c_rx = center[2*C +: C];
    assign c_ry = center[3*C +: C];
    assign t_lx = upper_left[0 +: C];
    assign t_ly = upper_left[C +: C];
    assign t_rx = upper_left[2*C +: C];
    assign t_ry = upper_left[3*C +: C];
    assign b_lx = lower_right[0 +: C];
    assign b_ly = lower_right[C +: C];
    assign b_rx = lower_right[2*C +: C];
    assign b_ry = lower_right[3*C +: C];

    // stage a: quadrant and selected distance / span
    logic                 a_valid_reg;
    logic                 a_found_reg, a_left_reg, a_top_reg;
    logic signed [SW-1:0] a_dx_reg, a_sx_reg, a_dy_reg, a_sy_reg;
    logic [C-1:0]         a_min_x_reg, a_min_y_reg;
    logic signed [C:0]    a_len_x_reg, a_len_y_reg;

    logic                 a_left_next, a_top_next;
    logic signed [SW-1:0] a_dx_next, a_sx_next, a_dy_next, a_sy_next;
    logic [C-1:0]         a_min_x_next, a_min_y_next;
    logic signed [C:0]    a_len_x_next, a_len_y_next;

    always_comb
    begin
        logic signed [SW-1:0] ox, oy, tx, ty;
        logic signed [SW-1:0] spl_x, spr_x, spl_y, spr_y;
        logic [C-1:0]         max_x, max_y;
        ox    = ext(left_eye_x) - ext(c_lx) + ext(right_eye_x) - ext(c_rx);
        oy    = ext(left_eye_y) - ext(c_ly) + ext(right_eye_y) - ext(c_ry);
        tx    = ext(left_eye_x) - ext(t_lx) + ext(right_eye_x) - ext(t_rx);
        ty    = ext(left_eye_y) - ext(t_ly) + ext(right_eye_y) - ext(t_ry);
        spl_x = ext(c_lx) - ext(t_lx) + ext(c_rx) - ext(t_rx);
        spr_x = ext(b_lx) - ext(c_lx) + ext(b_rx) - ext(c_rx);
        spl_y = ext(c_ly) - ext(t_ly) + ext(c_ry) - ext(t_ry);
        spr_y = ext(b_ly) - ext(c_ly) + ext(b_ry) - ext(c_ry);

        a_left_next = ox[SW-1] || (ox == '0);
        a_top_next  = oy[SW-1] || (oy == '0);
        a_dx_next   = a_left_next ? tx : ox;
        a_sx_next   = a_left_next ? spl_x : spr_x;
        a_dy_next   = a_top_next ? ty : oy;
        a_sy_next   = a_top_next ? spl_y : spr_y;

        a_min_x_next = (t_lx < t_rx) ? t_lx : t_rx;
        a_min_y_next = (t_ly < t_ry) ? t_ly : t_ry;
        max_x        = (b_lx > b_rx) ? b_lx : b_rx;
        max_y        = (b_ly > b_ry) ? b_ly : b_ry;
        a_len_x_next = $signed({1'b0, max_x}) - $signed({1'b0, a_min_x_next});
        a_len_y_next = $signed({1'b0, max_y}) - $signed({1'b0, a_min_y_next});
    end

    // stage b: status and divider operands
    logic              b_valid_reg;
    gqi_pkg::ctrl_t    b_ctrl_reg;
    logic [C:0]        b_dx_abs_reg, b_dy_abs_reg;
    logic [C+1:0]      b_den_x_reg, b_den_y_reg;
    logic [C-1:0]      b_min_x_reg, b_min_y_reg;
    logic signed [C:0] b_len_x_reg, b_len_y_reg;

    gqi_pkg::ctrl_t    b_ctrl_next;

    always_comb
    begin
        b_ctrl_next.x_right = !a_left_reg;
        b_ctrl_next.y_right = !a_top_reg;
        b_ctrl_next.x_neg   = a_dx_reg[SW-1] ^ a_sx_reg[SW-1];
        b_ctrl_next.y_neg   = a_dy_reg[SW-1] ^ a_sy_reg[SW-1];
        if (!a_found_reg)
        begin
            b_ctrl_next.status = gqi_pkg::STATUS_NO_EYES;
        end
        else if (a_sx_reg == '0 || a_sy_reg == '0)
        begin
            b_ctrl_next.status = gqi_pkg::STATUS_ZERO_SPAN;
        end
        else
        begin
            b_ctrl_next.status = gqi_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_found_reg  <= eyes_found;
            a_left_reg   <= a_left_next;
            a_top_reg    <= a_top_next;
            a_dx_reg     <= a_dx_next;
            a_sx_reg     <= a_sx_next;
            a_dy_reg     <= a_dy_next;
            a_sy_reg     <= a_sy_next;
            a_min_x_reg  <= a_min_x_next;
            a_min_y_reg  <= a_min_y_next;
            a_len_x_reg  <= a_len_x_next;
            a_len_y_reg  <= a_len_y_next;

            b_ctrl_reg   <= b_ctrl_next;
            b_dx_abs_reg <= mag(a_dx_reg);
            b_dy_abs_reg <= mag(a_dy_reg);
            b_den_x_reg  <= {mag(a_sx_reg), 1'b0};
            b_den_y_reg  <= {mag(a_sy_reg), 1'b0};
            b_min_x_reg  <= a_min_x_reg;
            b_min_y_reg  <= a_min_y_reg;
            b_len_x_reg  <= a_len_x_reg;
            b_len_y_reg  <= a_len_y_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign ctrl      = b_ctrl_reg;
    assign dx_abs    = b_dx_abs_reg;
    assign dy_abs    = b_dy_abs_reg;
    assign den_x     = b_den_x_reg;
    assign den_y     = b_den_y_reg;
    assign min_x     = b_min_x_reg;
    assign min_y     = b_min_y_reg;
    assign len_x     = b_len_x_reg;
    assign len_y     = b_len_y_reg;

endmodule

/* src/gqi_divider.sv */
// ----------------------------------------------------------------------------
// gqi_divider
// Pipelined restoring divider for unsigned operands: one quotient bit per
// stage, NUM_W stages, with a sideband word and a valid bit in step.
// ----------------------------------------------------------------------------
module gqi_divider #(
    parameter int NUM_W  = 29,
    parameter int DEN_W  = 14,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [NUM_W-1:0]  valid_reg;
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    logic [NUM_W-1:0]  valid_next;
    logic [NUM_W-1:0]  num_next  [NUM_W];
    logic [NUM_W-1:0]  quo_next  [NUM_W];
    logic [DEN_W-1:0]  rem_next  [NUM_W];
    logic [DEN_W-1:0]  den_next  [NUM_W];
    logic [SIDE_W-1:0] side_next [NUM_W];

    assign valid_next = {valid_reg[NUM_W-2:0], in_valid};

    always_comb
    begin
        logic [NUM_W-1:0] num_cur;
        logic [NUM_W-1:0] quo_cur;
        logic [DEN_W-1:0] rem_cur;
        logic [DEN_W-1:0] den_cur;
        logic [DEN_W:0]   trial;
        logic             fits;
        for (int i = 0; i < NUM_W; i++)
        begin
            if (i == 0)
            begin
                num_cur      = num;
                quo_cur      = '0;
                rem_cur      = '0;
                den_cur      = den;
                side_next[i] = side_in;
            end
            else
            begin
                num_cur      = num_reg[i-1];
                quo_cur      = quo_reg[i-1];
                rem_cur      = rem_reg[i-1];
                den_cur      = den_reg[i-1];
                side_next[i] = side_reg[i-1];
            end
            // remainder stays below the divisor, so the difference fits DEN_W
            trial       = {rem_cur, num_cur[NUM_W-1]};
            fits        = trial >= {1'b0, den_cur};
            rem_next[i] = fits ? DEN_W'(trial - {1'b0, den_cur}) : trial[DEN_W-1:0];
            quo_next[i] = {quo_cur[NUM_W-2:0], fits};
            num_next[i] = {num_cur[NUM_W-2:0], 1'b0};
            den_next[i] = den_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                num_reg[i]  <= num_next[i];
                quo_reg[i]  <= quo_next[i];
                rem_reg[i]  <= rem_next[i];
                den_reg[i]  <= den_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quo       = quo_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

/* src/gqi_mapper.sv */
// ----------------------------------------------------------------------------
// gqi_mapper
// Four stages per axis: signed fraction magnitude with the half offset,
// split partial products against the box length, product sum and scaling,
// then offset by the box corner with saturation.
// ----------------------------------------------------------------------------
module gqi_mapper #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int NUM_W      = 29
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  gqi_pkg::ctrl_t             ctrl,
    input  logic [NUM_W-1:0]           quo_x,
    input  logic [NUM_W-1:0]           quo_y,
    input  logic [COORD_BITS-1:0]      min_x,
    input  logic [COORD_BITS-1:0]      min_y,
    input  logic signed [COORD_BITS:0] len_x,
    input  logic signed [COORD_BITS:0] len_y,
    output logic                       out_valid,
    output gqi_pkg::status_t           status,
    output logic [COORD_BITS-1:0]      gaze_x,
    output logic [COORD_BITS-1:0]      gaze_y,
    output logic                       clipped
);

    localparam int C    = COORD_BITS;
    localparam int FM   = NUM_W + 1;
    localparam int LO_W = FM / 2;
    localparam int HI_W = FM - LO_W;
    localparam int PW   = FM + C;
    localparam int MW   = PW - FRAC_BITS;
    localparam int VW   = MW + 2;
    localparam logic [FM-1:0] HALF = {{(FM-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [NUM_W-1:0]  q_in   [2];
    logic              neg_in [2];
    logic              rgt_in [2];
    logic [C-1:0]      min_in [2];
    logic signed [C:0] len_in [2];

    assign q_in[0]   = quo_x;
    assign q_in[1]   = quo_y;
    assign neg_in[0] = ctrl.x_neg;
    assign neg_in[1] = ctrl.y_neg;
    assign rgt_in[0] = ctrl.x_right;
    assign rgt_in[1] = ctrl.y_right;
    assign min_in[0] = min_x;
    assign min_in[1] = min_y;
    assign len_in[0] = len_x;
    assign len_in[1] = len_y;

    logic [3:0]       valid_reg;
    gqi_pkg::status_t st1_reg, st2_reg, st3_reg, st4_reg;

    logic [FM-1:0]    fabs1_reg [2];
    logic [C-1:0]     labs1_reg [2];
    logic             pneg1_reg [2], pneg2_reg [2], pneg3_reg [2];
    logic [C-1:0]     min1_reg  [2], min2_reg  [2], min3_reg  [2];
    logic [LO_W+C-1:0] plo2_reg [2];
    logic [HI_W+C-1:0] phi2_reg [2];
    logic [MW-1:0]    mag3_reg  [2];
    logic [C-1:0]     gaze4_reg [2];
    logic             clip4_reg;

    logic [FM-1:0]    fabs1_next [2];
    logic [C-1:0]     labs1_next [2];
    logic             pneg1_next [2];
    logic [LO_W+C-1:0] plo2_next [2];
    logic [HI_W+C-1:0] phi2_next [2];
    logic [MW-1:0]    mag3_next  [2];
    logic [C-1:0]     gaze4_next [2];
    logic             clip4_next;

    // stage 1: |frac| and sign of the product
    always_comb
    begin
        logic [FM-1:0] qe;
        logic          q_gt;
        logic          fneg;
        logic [C:0]    lmag;
        for (int k = 0; k < 2; k++)
        begin
            qe   = {1'b0, q_in[k]};
            q_gt = qe > HALF;
            if (neg_in[k] && rgt_in[k])
            begin
                fabs1_next[k] = q_gt ? (qe - HALF) : (HALF - qe);
                fneg          = q_gt;
            end
            else if (neg_in[k])
            begin
                fabs1_next[k] = qe;
                fneg          = 1'b1;
            end
            else
            begin
                fabs1_next[k] = rgt_in[k] ? (qe + HALF) : qe;
                fneg          = 1'b0;
            end
            lmag          = len_in[k][C] ? -len_in[k] : len_in[k];
            labs1_next[k] = lmag[C-1:0];
            pneg1_next[k] = fneg ^ len_in[k][C];
        end
    end

    // stage 2: partial products, stage 3: sum and drop fraction bits
    always_comb
    begin
        logic [PW-1:0] prod;
        for (int k = 0; k < 2; k++)
        begin
            plo2_next[k] = fabs1_reg[k][LO_W-1:0] * labs1_reg[k];
            phi2_next[k] = fabs1_reg[k][FM-1:LO_W] * labs1_reg[k];
            prod         = (PW'(phi2_reg[k]) << LO_W) + PW'(plo2_reg[k]);
            mag3_next[k] = prod[PW-1:FRAC_BITS];
        end
    end

    // stage 4: corner offset and saturation
    always_comb
    begin
        logic signed [VW-1:0] base;
        logic signed [VW-1:0] step;
        logic signed [VW-1:0] v;
        clip4_next = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            base = $signed({{(VW-C){1'b0}}, min3_reg[k]});
            step = $signed({2'b00, mag3_reg[k]});
            v    = pneg3_reg[k] ? (base - step) : (base + step);
            if (v[VW-1])
            begin
                gaze4_next[k] = '0;
                clip4_next    = 1'b1;
            end
            else if (|v[VW-2:C])
            begin
                gaze4_next[k] = '1;
                clip4_next    = 1'b1;
            end
            else
            begin
                gaze4_next[k] = v[C-1:0];
            end
            if (st3_reg != gqi_pkg::STATUS_OK)
            begin
                gaze4_next[k] = '0;
            end
        end
        if (st3_reg != gqi_pkg::STATUS_OK)
        begin
            clip4_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_reg   <= ctrl.status;
            st2_reg   <= st1_reg;
            st3_reg   <= st2_reg;
            st4_reg   <= st3_reg;
            clip4_reg <= clip4_next;
            for (int k = 0; k < 2; k++)
            begin
                fabs1_reg[k] <= fabs1_next[k];
                labs1_reg[k] <= labs1_next[k];
                pneg1_reg[k] <= pneg1_next[k];
                min1_reg[k]  <= min_in[k];
                plo2_reg[k]  <= plo2_next[k];
                phi2_reg[k]  <= phi2_next[k];
                pneg2_reg[k] <= pneg1_reg[k];
                min2_reg[k]  <= min1_reg[k];
                mag3_reg[k]  <= mag3_next[k];
                pneg3_reg[k] <= pneg2_reg[k];
                min3_reg[k]  <= min2_reg[k];
                gaze4_reg[k] <= gaze4_next[k];
            end
        end
    end

    assign out_valid = valid_reg[3];
    assign status    = st4_reg;
    assign gaze_x    = gaze4_reg[0];
    assign gaze_y    = gaze4_reg[1];
    assign clipped   = clip4_reg;

endmodule

/* src/gaze_quadrant_interpolator.sv */
// ----------------------------------------------------------------------------
// gaze_quadrant_interpolator
// Maps left and right pupil positions to a screen point by quadrant
// interpolation between three calibration points.
//
//   channel   role     beat / access
//   eyes      sink     eyes_found, left/right pupil x and y
//   gaze      source   status, gaze_x, gaze_y, clipped
//   apb       slave    center, top-left, bottom-right points at 0x00/0x08/0x10
//
// one item per cycle while the pipe advances; the restoring dividers resolve one
// quotient bit per stage
// a two-entry output register and skid let the pipe take a beat while a result
// waits; the whole pipe holds only once the skid entry is occupied
// reset clears all valid bits and the calibration registers
// ----------------------------------------------------------------------------
module gaze_quadrant_interpolator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gqi_pkg::PADDR_W-1:0]  paddr,
    input  logic [gqi_pkg::PDATA_W-1:0]  pwdata,
    output logic [gqi_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    gqi_in_if.sink                       eyes,
    gqi_out_if.source                    gaze
);

    localparam int C       = COORD_BITS;
    localparam int NUM_W   = COORD_BITS + 1 + FRAC_BITS;
    localparam int DEN_W   = COORD_BITS + 2;
    localparam int CTRL_W  = $bits(gqi_pkg::ctrl_t);
    localparam int SIDE_XW = CTRL_W + 2 * C + 1;
    localparam int SIDE_YW = 2 * C + 1;

    logic [4*C-1:0] center, upper_left, lower_right;

    gqi_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .center       (center),
        .upper_left   (upper_left),
        .lower_right  (lower_right)
    );

    logic advance;

    logic              fr_valid;
    gqi_pkg::ctrl_t    fr_ctrl;
    logic [C:0]        fr_dx_abs, fr_dy_abs;
    logic [C+1:0]      fr_den_x, fr_den_y;
    logic [C-1:0]      fr_min_x, fr_min_y;
    logic signed [C:0] fr_len_x, fr_len_y;

    gqi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (eyes.valid),
        .eyes_found   (eyes.eyes_found),
        .left_eye_x   (eyes.left_eye_x),
        .left_eye_y   (eyes.left_eye_y),
        .right_eye_x  (eyes.right_eye_x),
        .right_eye_y  (eyes.right_eye_y),
        .center       (center),
        .upper_left   (upper_left),
        .lower_right  (lower_right),
        .out_valid    (fr_valid),
        .ctrl         (fr_ctrl),
        .dx_abs       (fr_dx_abs),
        .dy_abs       (fr_dy_abs),
        .den_x        (fr_den_x),
        .den_y        (fr_den_y),
        .min_x        (fr_min_x),
        .min_y        (fr_min_y),
        .len_x        (fr_len_x),
        .len_y        (fr_len_y)
    );

    logic               dv_x_valid, dv_y_valid;
    logic [NUM_W-1:0]   dv_quo_x, dv_quo_y;
    logic [SIDE_XW-1:0] dv_side_x;
    logic [SIDE_YW-1:0] dv_side_y;

    gqi_divider #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE_XW)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (fr_valid),
        .num       ({fr_dx_abs, {FRAC_BITS{1'b0}}}),
        .den       (fr_den_x),
        .side_in   ({fr_ctrl, fr_min_x, fr_len_x}),
        .out_valid (dv_x_valid),
        .quo       (dv_quo_x),
        .side_out  (dv_side_x)
    );

    gqi_divider #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE_YW)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (fr_valid),
        .num       ({fr_dy_abs, {FRAC_BITS{1'b0}}}),
        .den       (fr_den_y),
        .side_in   ({fr_min_y, fr_len_y}),
        .out_valid (dv_y_valid),
        .quo       (dv_quo_y),
        .side_out  (dv_side_y)
    );

    logic             mp_valid;
    gqi_pkg::status_t mp_status;
    logic [C-1:0]     mp_gaze_x, mp_gaze_y;
    logic             mp_clipped;

    gqi_mapper #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .NUM_W      (NUM_W)
    ) u_mapper (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (dv_x_valid),
        .ctrl      (gqi_pkg::ctrl_t'(dv_side_x[SIDE_XW-1 -: CTRL_W])),
        .quo_x     (dv_quo_x),
        .quo_y     (dv_quo_y),
        .min_x     (dv_side_x[2*C:C+1]),
        .min_y     (dv_side_y[2*C:C+1]),
        .len_x     ($signed(dv_side_x[C:0])),
        .len_y     ($signed(dv_side_y[C:0])),
        .out_valid (mp_valid),
        .status    (mp_status),
        .gaze_x    (mp_gaze_x),
        .gaze_y    (mp_gaze_y),
        .clipped   (mp_clipped)
    );

    // output register plus one skid entry
    logic             out_valid_reg, skid_valid_reg;
    gqi_pkg::status_t out_status_reg, skid_status_reg;
    logic [C-1:0]     out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;
    logic             out_clip_reg, skid_clip_reg;
    logic             out_free;
    logic             push;

    assign advance  = !skid_valid_reg;
    assign out_free = !out_valid_reg || gaze.ready;
    assign push     = advance && mp_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_status_reg <= skid_status_reg;
                out_x_reg      <= skid_x_reg;
                out_y_reg      <= skid_y_reg;
                out_clip_reg   <= skid_clip_reg;
            end
            else
            begin
                out_status_reg <= mp_status;
                out_x_reg      <= mp_gaze_x;
                out_y_reg      <= mp_gaze_y;
                out_clip_reg   <= mp_clipped;
            end
        end
        else if (push)
        begin
            skid_status_reg <= mp_status;
            skid_x_reg      <= mp_gaze_x;
            skid_y_reg      <= mp_gaze_y;
            skid_clip_reg   <= mp_clipped;
        end
    end

    assign eyes.ready   = advance;
    assign gaze.valid   = out_valid_reg;
    assign gaze.status  = out_status_reg;
    assign gaze.gaze_x  = out_x_reg;
    assign gaze.gaze_y  = out_y_reg;
    assign gaze.clipped = out_clip_reg;

    a_div_lanes_aligned: assert property (
        @(posedge clk) disable iff (!rst_n)
        dv_x_valid == dv_y_valid
    ) else $error("x and y divider lanes out of step");

    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid entry held with empty output register");

    a_skid_blocks_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !gaze.ready && push) |=> (skid_valid_reg && !eyes.ready)
    ) else $error("stalled beat not captured in skid");

    a_error_beat_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (gaze.valid && gaze.status != gqi_pkg::STATUS_OK)
            |-> (gaze.gaze_x == '0 && gaze.gaze_y == '0 && !gaze.clipped)
    ) else $error("error beat carries a nonzero point");

endmodule

/* tb/gqi_gaze_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqi_gaze_checker
// Watches the calibration bus and both channels of the gaze quadrant
// interpolator. It keeps its own copy of the calibration points, predicts the
// gaze point of every accepted eye sample and compares each gaze beat, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module gqi_gaze_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [gqi_pkg::PADDR_W-1:0] paddr,
    input  logic [gqi_pkg::PDATA_W-1:0] pwdata,
    gqi_in_if                           eyes,
    gqi_out_if                          gaze,
    output int                          mismatches,
    output int                          in_flight
);

    localparam int     CAL_W     = 4 * COORD_BITS;
    localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;
    localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS;
    localparam longint FRAC_HALF = longint'(1) << (FRAC_BITS - 1);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        gqi_pkg::status_t status;
        coord_t           gaze_x;
        coord_t           gaze_y;
        logic             clipped;
    } gaze_point_t;

    logic [CAL_W-1:0] center_cfg      = '0;
    logic [CAL_W-1:0] upper_left_cfg  = '0;
    logic [CAL_W-1:0] lower_right_cfg = '0;

    gaze_point_t expected_points [$];

    function automatic gaze_point_t interpolate_gaze(input logic found, input coord_t lx,
                                                     input coord_t ly, input coord_t rx,
                                                     input coord_t ry);
        gaze_point_t res;
        longint      eye [4];
        longint      cen [4];
        longint      tlp [4];
        longint      brp [4];
        longint      eye_dist [2];
        longint      span [2];
        bit          far_half [2];
        coord_t      sat [2];
        longint      offs;
        longint      frac;
        longint      lo;
        longint      hi;
        longint      pos;
        res.status  = gqi_pkg::STATUS_OK;
        res.gaze_x  = '0;
        res.gaze_y  = '0;
        res.clipped = 1'b0;
        if (!found)
        begin
            res.status = gqi_pkg::STATUS_NO_EYES;
            return res;
        end
        eye[0] = longint'(lx);
        eye[1] = longint'(ly);
        eye[2] = longint'(rx);
        eye[3] = longint'(ry);
        for (int k = 0; k < 4; k++)
        begin
            cen[k] = longint'(center_cfg[k*COORD_BITS +: COORD_BITS]);
            tlp[k] = longint'(upper_left_cfg[k*COORD_BITS +: COORD_BITS]);
            brp[k] = longint'(lower_right_cfg[k*COORD_BITS +: COORD_BITS]);
        end
        // axis 0 is x (fields 0 and 2), axis 1 is y (fields 1 and 3)
        for (int a = 0; a < 2; a++)
        begin
            offs        = (eye[a] - cen[a]) + (eye[a+2] - cen[a+2]);
            far_half[a] = offs > 0;
            if (far_half[a])
            begin
                span[a]     = (brp[a] - cen[a]) + (brp[a+2] - cen[a+2]);
                eye_dist[a] = offs;
            end
            else
            begin
                span[a]     = (cen[a] - tlp[a]) + (cen[a+2] - tlp[a+2]);
                eye_dist[a] = (eye[a] - tlp[a]) + (eye[a+2] - tlp[a+2]);
            end
        end
        if (span[0] == 0 || span[1] == 0)
        begin
            res.status = gqi_pkg::STATUS_ZERO_SPAN;
            return res;
        end
        for (int a = 0; a < 2; a++)
        begin
            // signed division truncates toward zero
            frac = (eye_dist[a] * FRAC_ONE) / (2 * span[a]);
            if (far_half[a])
                frac += FRAC_HALF;
            lo  = (tlp[a] < tlp[a+2]) ? tlp[a] : tlp[a+2];
            hi  = (brp[a] > brp[a+2]) ? brp[a] : brp[a+2];
            pos = (frac * (hi - lo)) / FRAC_ONE + lo;
            if (pos < 0)
            begin
                sat[a]      = '0;
                res.clipped = 1'b1;
            end
            else if (pos > COORD_MAX)
            begin
                sat[a]      = '1;
                res.clipped = 1'b1;
            end
            else
                sat[a] = coord_t'(pos);
        end
        res.gaze_x = sat[0];
        res.gaze_y = sat[1];
        return res;
    endfunction

    always @(posedge clk)
    begin
        gaze_point_t seen;
        gaze_point_t want;
        if (!rst_n)
        begin
            center_cfg      = '0;
            upper_left_cfg  = '0;
            lower_right_cfg = '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[gqi_pkg::PADDR_W-1:gqi_pkg::REG_ADDR_LSB])
                    gqi_pkg::REG_CENTER:       center_cfg      = pwdata[CAL_W-1:0];
                    gqi_pkg::REG_TOP_LEFT:     upper_left_cfg  = pwdata[CAL_W-1:0];
                    gqi_pkg::REG_BOTTOM_RIGHT: lower_right_cfg = pwdata[CAL_W-1:0];
                    default: ;
                endcase
            end
            if (eyes.valid && eyes.ready)
                expected_points.push_back(interpolate_gaze(eyes.eyes_found, eyes.left_eye_x,
                                                           eyes.left_eye_y, eyes.right_eye_x,
                                                           eyes.right_eye_y));
            if (gaze.valid && gaze.ready)
            begin
                seen.status  = gaze.status;
                seen.gaze_x  = gaze.gaze_x;
                seen.gaze_y  = gaze.gaze_y;
                seen.clipped = gaze.clipped;
                if (expected_points.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%0t: gaze beat with no sample pending: ",
                                  "status=%0d x=%0d y=%0d clipped=%0b"},
                                 $realtime, seen.status, seen.gaze_x, seen.gaze_y,
                                 seen.clipped);
                    mismatches++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (seen.status !== want.status || seen.gaze_x !== want.gaze_x ||
                        seen.gaze_y !== want.gaze_y || seen.clipped !== want.clipped)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: gaze mismatch: expected status=%0d x=%0d y=%0d ",
                                      "clipped=%0b, got status=%0d x=%0d y=%0d clipped=%0b"},
                                     $realtime, want.status, want.gaze_x, want.gaze_y,
                                     want.clipped, seen.status, seen.gaze_x, seen.gaze_y,
                                     seen.clipped);
                        mismatches++;
                    end
                end
            end
        end
        in_flight <= expected_points.size();
    end

endmodule

/* tb/tb_gaze_quadrant_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaze_quadrant_interpolator
// Drives calibration writes and eye samples into the gaze quadrant
// interpolator: a directed set over reset, regular, zero-span, misordered and
// extreme calibrations, then randomized phases with random gaps on both
// channels, a long output stall and full drains between phases.
// ----------------------------------------------------------------------------
module tb_gaze_quadrant_interpolator;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int CAL_W        = 4 * COORD_BITS;
    localparam int PIPE_LATENCY = COORD_BITS + FRAC_BITS + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 75;

    // no register decodes to this index
    localparam logic [gqi_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef logic [COORD_BITS-1:0] coord_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [gqi_pkg::PADDR_W-1:0] paddr;
    logic [gqi_pkg::PDATA_W-1:0] pwdata;
    logic [gqi_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    int                          mismatches;
    int                          in_flight;

    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    int hold_off_len = 0;

    logic [CAL_W-1:0] cal_center      = '0;
    logic [CAL_W-1:0] cal_upper_left  = '0;
    logic [CAL_W-1:0] cal_lower_right = '0;

    gqi_in_if  #(.COORD_BITS(COORD_BITS)) eyes_ch ();
    gqi_out_if #(.COORD_BITS(COORD_BITS)) gaze_ch ();

    gaze_quadrant_interpolator #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eyes    (eyes_ch),
        .gaze    (gaze_ch)
    );

    gqi_gaze_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .eyes       (eyes_ch),
        .gaze       (gaze_ch),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [CAL_W-1:0] pack_point(input coord_t lx, input coord_t ly,
                                                     input coord_t rx, input coord_t ry);
        return {ry, rx, ly, lx};
    endfunction

    task automatic write_reg(input logic [gqi_pkg::REG_IDX_W-1:0] idx,
                             input logic [CAL_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, {gqi_pkg::REG_ADDR_LSB{1'b0}}};
        pwdata  <= gqi_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_calibration(input logic [CAL_W-1:0] tl, input logic [CAL_W-1:0] c,
                                    input logic [CAL_W-1:0] br);
        write_reg(gqi_pkg::REG_TOP_LEFT, tl);
        write_reg(gqi_pkg::REG_CENTER, c);
        write_reg(gqi_pkg::REG_BOTTOM_RIGHT, br);
        cal_upper_left  = tl;
        cal_center      = c;
        cal_lower_right = br;
    endtask

    task automatic send_sample(input logic found, input coord_t lx, input coord_t ly,
                               input coord_t rx, input coord_t ry);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            eyes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        eyes_ch.valid       <= 1'b1;
        eyes_ch.eyes_found  <= found;
        eyes_ch.left_eye_x  <= lx;
        eyes_ch.left_eye_y  <= ly;
        eyes_ch.right_eye_x <= rx;
        eyes_ch.right_eye_y <= ry;
        do @(posedge clk); while (!eyes_ch.ready);
    endtask

    task automatic stop_samples();
        eyes_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        do @(posedge clk); while (in_flight != 0);
    endtask

    task automatic pick_calibration(output logic [CAL_W-1:0] tl, output logic [CAL_W-1:0] c,
                                    output logic [CAL_W-1:0] br);
        int kind;
        int t;
        int m;
        int b;
        kind = $urandom_range(0, 3);
        if (kind == 0)
        begin
            tl = CAL_W'({$urandom, $urandom});
            c  = CAL_W'({$urandom, $urandom});
            br = CAL_W'({$urandom, $urandom});
        end
        else
        begin
            // ordered points per field; the narrow kind often gives zero spans
            for (int k = 0; k < 4; k++)
            begin
                t = $urandom_range(0, 1800);
                m = t + ((kind == 1) ? $urandom_range(0, 2) : $urandom_range(1, 1200));
                b = m + ((kind == 1) ? $urandom_range(0, 2) : $urandom_range(1, 1000));
                tl[k*COORD_BITS +: COORD_BITS] = coord_t'(t);
                c[k*COORD_BITS +: COORD_BITS]  = coord_t'(m);
                br[k*COORD_BITS +: COORD_BITS] = coord_t'(b);
            end
        end
    endtask

    function automatic coord_t pick_coord(input int k);
        int lo;
        int hi;
        int mid;
        int pick;
        lo   = int'(cal_upper_left[k*COORD_BITS +: COORD_BITS]) - 80;
        hi   = int'(cal_lower_right[k*COORD_BITS +: COORD_BITS]) + 80;
        mid  = int'(cal_center[k*COORD_BITS +: COORD_BITS]) + $urandom_range(0, 6) - 3;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return coord_t'($urandom);
        // near the center so the quadrant choice flips around a zero offset
        if (pick < 5)
            return coord_t'((mid < 0) ? 0 : (mid > 4095) ? 4095 : mid);
        lo = (lo < 0) ? 0 : (lo > 4095) ? 4095 : lo;
        hi = (hi < 0) ? 0 : (hi > 4095) ? 4095 : hi;
        return coord_t'($urandom_range(hi, lo));
    endfunction

    task automatic send_random_sample();
        send_sample($urandom_range(0, 9) != 0, pick_coord(0), pick_coord(1), pick_coord(2),
                    pick_coord(3));
    endtask

    // output side: random stall per beat, plus a long hold when asked
    initial
    begin
        int stall;
        gaze_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_len > 0)
            begin
                gaze_ch.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            stall = rx_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                gaze_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            gaze_ch.ready <= 1'b1;
            do @(posedge clk); while (!gaze_ch.valid);
        end
    end

    initial
    begin
        logic [CAL_W-1:0] tl;
        logic [CAL_W-1:0] c;
        logic [CAL_W-1:0] br;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        eyes_ch.valid       <= 1'b0;
        eyes_ch.eyes_found  <= 1'b0;
        eyes_ch.left_eye_x  <= '0;
        eyes_ch.left_eye_y  <= '0;
        eyes_ch.right_eye_x <= '0;
        eyes_ch.right_eye_y <= '0;
        rst_n               <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: every span is zero
        send_sample(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
        send_sample(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_sample(1'b0, 12'd1234, 12'd567, 12'd890, 12'd2345);
        stop_samples();
        wait_for_results();

        write_reg(REG_UNMAPPED, pack_point(12'd4095, 12'd4095, 12'd4095, 12'd4095));
        load_calibration(pack_point(12'd200, 12'd150, 12'd220, 12'd160),
                         pack_point(12'd2000, 12'd1500, 12'd2020, 12'd1520),
                         pack_point(12'd3900, 12'd3000, 12'd3920, 12'd3020));
        send_sample(1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_sample(1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
        // offsets sum to exactly zero: left and top halves
        send_sample(1'b1, 12'd2000, 12'd1500, 12'd2020, 12'd1520);
        send_sample(1'b1, 12'd2100, 12'd1400, 12'd1920, 12'd1620);
        send_sample(1'b1, 12'd2001, 12'd1501, 12'd2020, 12'd1520);
        send_sample(1'b1, 12'd200, 12'd150, 12'd220, 12'd160);
        send_sample(1'b1, 12'd3900, 12'd3000, 12'd3920, 12'd3020);
        send_sample(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
        send_sample(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_sample(1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095);
        send_sample(1'b1, 12'd0, 12'd4095, 12'd4095, 12'd0);
        stop_samples();
        wait_for_results();

        // zero span in the left half only
        load_calibration(pack_point(12'd2000, 12'd150, 12'd2020, 12'd160),
                         pack_point(12'd2000, 12'd1500, 12'd2020, 12'd1520),
                         pack_point(12'd3900, 12'd3000, 12'd3920, 12'd3020));
        send_sample(1'b1, 12'd1000, 12'd1000, 12'd1000, 12'd1000);
        send_sample(1'b1, 12'd3000, 12'd2000, 12'd3000, 12'd2000);
        stop_samples();
        wait_for_results();

        // misordered corners: negative spans and lengths
        load_calibration(pack_point(12'd3900, 12'd3000, 12'd3920, 12'd3020),
                         pack_point(12'd2000, 12'd1500, 12'd2020, 12'd1520),
                         pack_point(12'd200, 12'd150, 12'd220, 12'd160));
        send_sample(1'b1, 12'd1000, 12'd800, 12'd1000, 12'd800);
        send_sample(1'b1, 12'd3000, 12'd2500, 12'd3000, 12'd2500);
        stop_samples();
        wait_for_results();

        load_calibration('1, '1, '1);
        send_sample(1'b1, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
        stop_samples();
        wait_for_results();

        load_calibration('0, pack_point(12'd2048, 12'd2048, 12'd2048, 12'd2048), '1);
        send_sample(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
        send_sample(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_sample(1'b1, 12'd2049, 12'd2047, 12'd2048, 12'd2048);
        stop_samples();
        wait_for_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            pick_calibration(tl, c, br);
            load_calibration(tl, c, br);
            case (phase)
                0: begin tx_idle = 1'b1; rx_idle = 1'b1; end
                1: begin tx_idle = 1'b0; rx_idle = 1'b0; end
                2:
                begin
                    // back-to-back input against a long output hold fills the pipe
                    tx_idle      = 1'b0;
                    rx_idle      = 1'b1;
                    hold_off_len = HOLD_CYCLES;
                end
                3: begin tx_idle = 1'b1; rx_idle = 1'b0; end
                4: begin tx_idle = 1'b0; rx_idle = 1'b1; end
                default: begin tx_idle = 1'b1; rx_idle = 1'b1; end
            endcase
            repeat (PHASE_ITEMS) send_random_sample();
            stop_samples();
            wait_for_results();
        end

        repeat (PIPE_LATENCY + 12) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/gqi_pkg.sv
src/gqi_in_if.sv
src/gqi_out_if.sv
src/gqi_cfg_regs.sv
src/gqi_front.sv
src/gqi_divider.sv
src/gqi_mapper.sv
src/gaze_quadrant_interpolator.sv
tb/gqi_gaze_checker.sv
tb/tb_gaze_quadrant_interpolator.sv
